### sv/bfa_pkg.sv
`default_nettype none
package bfa_pkg;

	localparam int MAX_FRAMES = 4096;
	localparam int WORD_BITS  = 32;
	localparam int MAP_WORDS  = MAX_FRAMES / WORD_BITS;
	localparam int WADDR_W    = $clog2(MAP_WORDS);
	localparam int BIT_W      = $clog2(WORD_BITS);
	localparam int FRAME_W    = 12;
	localparam int COUNT_W    = 13;

	localparam logic [COUNT_W-1:0] TOTAL_BLOCKS_RESET = COUNT_W'(4096);

	typedef logic [WORD_BITS-1:0] word_t;

	typedef enum logic [1:0] {
		FUNC_ALLOC       = 2'd0,
		FUNC_FREE        = 2'd1,
		FUNC_REGION_FREE = 2'd2,
		FUNC_REGION_USED = 2'd3
	} func_t;

	typedef enum logic [1:0] {
		ST_DONE       = 2'd0,
		ST_NO_RUN     = 2'd1,
		ST_ZERO_COUNT = 2'd2
	} status_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_CHECK,
		S_SCAN,
		S_WSETUP,
		S_WRITE,
		S_FIX0,
		S_FINISH,
		S_OUT
	} state_t;

	typedef struct packed {
		logic load_req;
		logic check;
		logic scan_step;
		logic scan_miss;
		logic write_setup;
		logic write_step;
		logic fix0;
		logic cnt_update;
		logic load_out;
	} ctrl_cmd_t;

	typedef struct packed {
		logic is_alloc;
		logic zero_count;
		logic cnt_zero;
		logic hit;
		logic scan_last;
		logic write_last;
		logic region_free;
	} dp_stat_t;

endpackage
`default_nettype wire

### sv/bfa_ifs.sv
`default_nettype none
interface bfa_req_if;
	import bfa_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         func;
	logic [FRAME_W-1:0] frame_index;
	logic [COUNT_W-1:0] count;

	modport source (output valid, func, frame_index, count, input ready);
	modport sink (input valid, func, frame_index, count, output ready);
endinterface

interface bfa_rsp_if;
	import bfa_pkg::*;

	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [FRAME_W-1:0] alloc_frame;
	logic [COUNT_W-1:0] free_frames;

	modport source (output valid, status, alloc_frame, free_frames, input ready);
	modport sink (input valid, status, alloc_frame, free_frames, output ready);
endinterface
`default_nettype wire

### sv/bitmap_frame_allocator_unit.sv
// Allocate scans for a free run, then writes the bitmap words the run touches; free and
// mark-used write those words directly; mark-free then also sets frame 0 to used.
// Zero-count or no-free-frame requests skip scan and writes (not the frame 0 write).
// A result waits for rsp.ready to take the last one. One request at a time: the next
// is accepted the cycle after the result loads; the scan reads one 32-frame word a cycle.
// Reset: every frame used, free count zero, total_blocks 4096; no clearing pass needed.
`default_nettype none
module bitmap_frame_allocator_unit (
	input  logic                        clk,
	input  logic                        arst_n,
	bfa_req_if.sink                     req,
	bfa_rsp_if.source                   rsp,
	input  logic                        cfg_we,
	input  logic [bfa_pkg::COUNT_W-1:0] cfg_wdata
);
	import bfa_pkg::*;

	ctrl_cmd_t cmd;
	dp_stat_t  stat;

	bfa_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (req.valid),
		.in_ready  (req.ready),
		.out_valid (rsp.valid),
		.out_ready (rsp.ready),
		.stat      (stat),
		.cmd       (cmd)
	);

	bfa_dp u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.stat            (stat),
		.in_func         (req.func),
		.in_frame_index  (req.frame_index),
		.in_count        (req.count),
		.cfg_we          (cfg_we),
		.cfg_wdata       (cfg_wdata),
		.out_status      (rsp.status),
		.out_alloc_frame (rsp.alloc_frame),
		.out_free_frames (rsp.free_frames)
	);

endmodule
`default_nettype wire

### sv/bfa_ctrl.sv
`default_nettype none
module bfa_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	output logic                out_valid,
	input  logic                out_ready,
	input  bfa_pkg::dp_stat_t   stat,
	output bfa_pkg::ctrl_cmd_t  cmd
);
	import bfa_pkg::*;

	state_t state_q;
	state_t state_nxt;
	logic   out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		in_ready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load_req = 1'b1;
					state_nxt    = S_CHECK;
				end
			end
			S_CHECK: begin
				cmd.check = 1'b1;
				if (stat.is_alloc) begin
					if (stat.zero_count || stat.cnt_zero) begin
						state_nxt = S_FINISH;
					end else begin
						state_nxt = S_SCAN;
					end
				end else if (stat.zero_count) begin
					state_nxt = stat.region_free ? S_FIX0 : S_FINISH;
				end else begin
					state_nxt = S_WSETUP;
				end
			end
			S_SCAN: begin
				// stop issuing reads once the scan ends so no stale word is processed
				if (stat.hit) begin
					state_nxt = S_WSETUP;
				end else if (stat.scan_last) begin
					cmd.scan_miss = 1'b1;
					state_nxt     = S_FINISH;
				end else begin
					cmd.scan_step = 1'b1;
				end
			end
			S_WSETUP: begin
				cmd.write_setup = 1'b1;
				state_nxt       = S_WRITE;
			end
			S_WRITE: begin
				cmd.write_step = 1'b1;
				if (stat.write_last) begin
					state_nxt = stat.region_free ? S_FIX0 : S_FINISH;
				end
			end
			S_FIX0: begin
				cmd.fix0  = 1'b1;
				state_nxt = S_FINISH;
			end
			S_FINISH: begin
				cmd.cnt_update = 1'b1;
				state_nxt      = S_OUT;
			end
			S_OUT: begin
				// hold until the output register is free
				if (!out_valid_q || out_ready) begin
					cmd.load_out = 1'b1;
					state_nxt    = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	assign out_valid = out_valid_q;

endmodule
`default_nettype wire

### sv/bfa_dp.sv
`default_nettype none
module bfa_dp (
	input  logic                         clk,
	input  logic                         arst_n,
	input  bfa_pkg::ctrl_cmd_t           cmd,
	output bfa_pkg::dp_stat_t            stat,
	input  logic [1:0]                   in_func,
	input  logic [bfa_pkg::FRAME_W-1:0]  in_frame_index,
	input  logic [bfa_pkg::COUNT_W-1:0]  in_count,
	input  logic                         cfg_we,
	input  logic [bfa_pkg::COUNT_W-1:0]  cfg_wdata,
	output logic [1:0]                   out_status,
	output logic [bfa_pkg::FRAME_W-1:0]  out_alloc_frame,
	output logic [bfa_pkg::COUNT_W-1:0]  out_free_frames
);
	import bfa_pkg::*;

	function automatic logic [BIT_W-1:0] lowest_set(input word_t v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = WORD_BITS - 1; i >= 0; i--) begin
			if (v[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	function automatic logic [BIT_W-1:0] highest_set(input word_t v);
		logic [BIT_W-1:0] idx;
		idx = '0;
		for (int i = 0; i < WORD_BITS; i++) begin
			if (v[i]) idx = BIT_W'(i);
		end
		return idx;
	endfunction

	localparam logic [COUNT_W-1:0] MAX_CNT = COUNT_W'(MAX_FRAMES);

	// bitmap storage, one row per word; a row never written reads as all used
	word_t              map_q [MAP_WORDS];
	logic [MAP_WORDS-1:0] row_valid_q;

	// request and result registers
	func_t              func_q;
	logic [COUNT_W-1:0] n_q;
	logic [FRAME_W-1:0] run_start_q;
	status_t            status_q;
	logic [FRAME_W-1:0] alloc_frame_q;
	logic [COUNT_W-1:0] free_cnt_q;
	logic [COUNT_W-1:0] total_blocks_q;
	logic [COUNT_W-1:0] run_q;
	logic [WADDR_W-1:0] raddr_q;
	logic [WADDR_W-1:0] wptr_q;
	logic [COUNT_W-1:0] end_q;
	status_t            out_status_q;
	logic [FRAME_W-1:0] out_alloc_frame_q;
	logic [COUNT_W-1:0] out_free_frames_q;

	// read pipeline
	word_t              rdata_s1;
	logic               rowv_s1;
	logic [WADDR_W-1:0] word_s1;
	logic               proc_valid_s1;

	// scan logic
	logic [COUNT_W-1:0] limit_c;
	logic [WADDR_W:0]   lim_word_c;
	word_t              rword_c;
	word_t              allow_c;
	word_t              free_c;
	word_t              r_lv [BIT_W+1];
	word_t              acc_c;
	logic [BIT_W:0]     sh_c;
	logic               small_c;
	logic               int_hit_c;
	logic [BIT_W:0]     trail_c;
	logic [BIT_W:0]     lead_c;
	logic [COUNT_W-1:0] need_c;
	logic [COUNT_W-1:0] need_m1_c;
	logic               cross_c;
	logic [BIT_W-1:0]   j_c;
	logic               hit_c;
	logic [COUNT_W-1:0] start_full_c;
	logic [FRAME_W-1:0] hit_start_c;
	logic [COUNT_W-1:0] run_nxt_c;

	// write logic
	logic [COUNT_W:0]   end_full_c;
	logic [BIT_W-1:0]   lo_c;
	logic [BIT_W-1:0]   hi_c;
	word_t              run_mask_c;
	logic [WADDR_W-1:0] last_word_c;
	logic               fill_used_c;
	logic               we_c;
	logic [WADDR_W-1:0] waddr_c;
	word_t              wmask_c;
	logic               wfill_c;
	word_t              wbe_c;
	word_t              wval_c;

	// counter
	logic [COUNT_W:0]   sum_c;
	logic [COUNT_W-1:0] add_c;
	logic [COUNT_W-1:0] sub_c;

	always_comb begin
		limit_c    = (total_blocks_q > MAX_CNT) ? MAX_CNT : total_blocks_q;
		lim_word_c = limit_c[COUNT_W-1:BIT_W];
		rword_c    = rowv_s1 ? rdata_s1 : '1;
		if ({1'b0, word_s1} < lim_word_c) begin
			allow_c = '1;
		end else if ({1'b0, word_s1} == lim_word_c) begin
			allow_c = ~('1 << limit_c[BIT_W-1:0]);
		end else begin
			allow_c = '0;
		end
		free_c = ~rword_c & allow_c;

		// r_lv[k][j]: the 2**k frames ending at bit j are all free
		r_lv[0] = free_c;
		for (int k = 1; k <= BIT_W; k++) begin
			r_lv[k] = r_lv[k-1] & (r_lv[k-1] << (1 << (k - 1)));
		end
		// combine powers of two into a window of n frames
		acc_c = '1;
		sh_c  = '0;
		for (int k = 0; k <= BIT_W; k++) begin
			if (n_q[k]) begin
				acc_c = acc_c & (r_lv[k] << sh_c);
				sh_c  = sh_c + (BIT_W+1)'(1 << k);
			end
		end
		small_c   = (n_q[COUNT_W-1:BIT_W+1] == '0);
		int_hit_c = small_c && (|acc_c);

		trail_c = (&free_c) ? (BIT_W+1)'(WORD_BITS) : {1'b0, lowest_set(~free_c)};
		lead_c  = (&free_c) ? (BIT_W+1)'(WORD_BITS)
		                    : (BIT_W+1)'(WORD_BITS - 1) - {1'b0, highest_set(~free_c)};

		// a run carried in from lower words completes at bit need-1
		need_c    = n_q - run_q;
		need_m1_c = need_c - COUNT_W'(1);
		cross_c   = (need_c <= {{(COUNT_W-BIT_W-1){1'b0}}, trail_c});
		j_c       = cross_c ? need_m1_c[BIT_W-1:0] : lowest_set(acc_c);
		hit_c     = proc_valid_s1 && (cross_c || int_hit_c);

		start_full_c = {1'b0, word_s1, j_c} + COUNT_W'(1) - n_q;
		hit_start_c  = start_full_c[FRAME_W-1:0];
		run_nxt_c    = (trail_c == (BIT_W+1)'(WORD_BITS))
		               ? run_q + COUNT_W'(WORD_BITS)
		               : {{(COUNT_W-BIT_W-1){1'b0}}, lead_c};
	end

	always_comb begin
		// last frame of the run, one bit wider so a long run cannot wrap
		end_full_c = {2'b0, run_start_q} + {1'b0, n_q} - (COUNT_W+1)'(1);
		lo_c = (wptr_q == run_start_q[FRAME_W-1:BIT_W]) ? run_start_q[BIT_W-1:0] : '0;
		hi_c = (!end_q[COUNT_W-1] && wptr_q == end_q[COUNT_W-2:BIT_W])
		       ? end_q[BIT_W-1:0] : '1;
		run_mask_c  = ('1 << lo_c) & ('1 >> (BIT_W'(WORD_BITS - 1) - hi_c));
		last_word_c = end_q[COUNT_W-1] ? '1 : end_q[COUNT_W-2:BIT_W];
		fill_used_c = (func_q inside {FUNC_ALLOC, FUNC_REGION_USED});

		we_c    = cmd.write_step || cmd.fix0;
		waddr_c = cmd.fix0 ? '0 : wptr_q;
		wmask_c = cmd.fix0 ? word_t'(1) : run_mask_c;
		wfill_c = cmd.fix0 ? 1'b1 : fill_used_c;
		// first write to a row fills the untouched bits with used
		if (row_valid_q[waddr_c]) begin
			wbe_c  = wmask_c;
			wval_c = {WORD_BITS{wfill_c}};
		end else begin
			wbe_c  = '1;
			wval_c = ({WORD_BITS{wfill_c}} & wmask_c) | ~wmask_c;
		end

		sum_c = {1'b0, free_cnt_q} + {1'b0, n_q};
		add_c = (sum_c > {1'b0, MAX_CNT}) ? MAX_CNT : sum_c[COUNT_W-1:0];
		sub_c = (n_q > free_cnt_q) ? '0 : free_cnt_q - n_q;
	end

	always_ff @(posedge clk) begin
		rdata_s1 <= map_q[raddr_q];
		rowv_s1  <= row_valid_q[raddr_q];
		word_s1  <= raddr_q;
		if (we_c) begin
			for (int b = 0; b < WORD_BITS; b++) begin
				if (wbe_c[b]) map_q[waddr_c][b] <= wval_c[b];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_valid_q    <= '0;
			proc_valid_s1  <= 1'b0;
			free_cnt_q     <= '0;
			total_blocks_q <= TOTAL_BLOCKS_RESET;
		end else begin
			proc_valid_s1 <= cmd.scan_step;
			if (we_c) begin
				row_valid_q[waddr_c] <= 1'b1;
			end
			if (cfg_we) begin
				total_blocks_q <= cfg_wdata;
			end
			if (cmd.cnt_update && status_q == ST_DONE) begin
				free_cnt_q <= fill_used_c ? sub_c : add_c;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load_req) begin
			func_q      <= func_t'(in_func);
			n_q         <= in_count;
			run_start_q <= in_frame_index;
		end
		if (cmd.check) begin
			if (func_q == FUNC_ALLOC && n_q == '0) begin
				status_q <= ST_ZERO_COUNT;
			end else if (func_q == FUNC_ALLOC && free_cnt_q == '0) begin
				status_q <= ST_NO_RUN;
			end else begin
				status_q <= ST_DONE;
			end
			alloc_frame_q <= '0;
			run_q         <= '0;
			raddr_q       <= '0;
		end
		if (cmd.scan_step) begin
			raddr_q <= raddr_q + WADDR_W'(1);
		end
		if (hit_c) begin
			run_start_q   <= hit_start_c;
			alloc_frame_q <= hit_start_c;
		end else if (proc_valid_s1) begin
			run_q <= run_nxt_c;
		end
		if (cmd.scan_miss) begin
			status_q <= ST_NO_RUN;
		end
		if (cmd.write_setup) begin
			wptr_q <= run_start_q[FRAME_W-1:BIT_W];
			// clamp past the map so the sweep stops at the last word
			end_q  <= end_full_c[COUNT_W] ? '1 : end_full_c[COUNT_W-1:0];
		end
		if (cmd.write_step) begin
			wptr_q <= wptr_q + WADDR_W'(1);
		end
		if (cmd.load_out) begin
			out_status_q      <= status_q;
			out_alloc_frame_q <= alloc_frame_q;
			out_free_frames_q <= free_cnt_q;
		end
	end

	always_comb begin
		stat.is_alloc    = (func_q == FUNC_ALLOC);
		stat.zero_count  = (n_q == '0);
		stat.cnt_zero    = (free_cnt_q == '0);
		stat.hit         = hit_c;
		stat.scan_last   = proc_valid_s1 && (word_s1 == WADDR_W'(MAP_WORDS - 1));
		stat.write_last  = (wptr_q == last_word_c);
		stat.region_free = (func_q == FUNC_REGION_FREE);
	end

	assign out_status      = out_status_q;
	assign out_alloc_frame = out_alloc_frame_q;
	assign out_free_frames = out_free_frames_q;

endmodule
`default_nettype wire
